>>> hw/rtl/vstc_pkg.sv
package vstc_pkg;

	localparam int DIVIDEND_W = 30;
	localparam int DIVISOR_W  = 10;
	localparam int CNT_W      = $clog2(DIVIDEND_W);
	localparam int MAG_W      = 15;
	localparam int PADDR_W    = 5;

	localparam logic [MAG_W-1:0]     ONE_Q14   = 15'd16384;
	localparam logic [9:0]           LEFT_REF  = 10'd60;
	localparam logic [9:0]           RIGHT_REF = 10'd260;
	localparam logic [13:0]          MAX_DIST  = 14'd3072;
	localparam logic [DIVISOR_W-1:0] FWD_DIV   = 10'd24;

	typedef enum logic [2:0] {
		CMD_START      = 3'd0,
		CMD_DISTANCE   = 3'd1,
		CMD_IMAGE      = 3'd2,
		CMD_TICK       = 3'd3,
		CMD_DEACTIVATE = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		ACT_LEFT    = 2'd0,
		ACT_RIGHT   = 2'd1,
		ACT_FORWARD = 2'd2,
		ACT_STOP    = 2'd3
	} action_t;

	localparam logic [2:0] REG_CAMERA_ID   = 3'd0;
	localparam logic [2:0] REG_WINDOW_LOW  = 3'd1;
	localparam logic [2:0] REG_WINDOW_HIGH = 3'd2;
	localparam logic [2:0] REG_SPEED_SCALE = 3'd3;
	localparam logic [2:0] REG_MIN_DIST    = 3'd4;
	localparam logic [2:0] REG_TIMEOUT     = 3'd5;

	typedef struct packed {
		logic [7:0]  camera_id;
		logic [9:0]  window_low_x;
		logic [9:0]  window_high_x;
		logic [9:0]  speed_scale;
		logic [11:0] min_distance;
		logic [15:0] timeout_ticks;
	} cfg_t;

endpackage

>>> hw/rtl/vstc_if.sv
interface vstc_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  cmd;
	logic        from_partner;
	logic        tracking;
	logic [7:0]  camera;
	logic [13:0] coord_value;

	modport source(output valid, cmd, from_partner, tracking, camera, coord_value,
		input ready);
	modport sink(input valid, cmd, from_partner, tracking, camera, coord_value,
		output ready);
endinterface

interface vstc_res_if;
	logic               valid;
	logic               ready;
	logic [1:0]         action;
	logic signed [15:0] thrust_port;
	logic signed [15:0] thrust_starboard;

	modport source(output valid, action, thrust_port, thrust_starboard, input ready);
	modport sink(input valid, action, thrust_port, thrust_starboard, output ready);
endinterface

>>> hw/rtl/vstc_regs.sv
module vstc_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [vstc_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	output vstc_pkg::cfg_t                cfg
);

	vstc_pkg::cfg_t cfg_q;
	logic [2:0]     idx;
	logic           wr_en;

	assign idx    = paddr[4:2];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.camera_id     <= 8'd1;
			cfg_q.window_low_x  <= 10'd130;
			cfg_q.window_high_x <= 10'd190;
			cfg_q.speed_scale   <= 10'd384;
			cfg_q.min_distance  <= 12'd384;
			cfg_q.timeout_ticks <= 16'd2000;
		end else if (wr_en) begin
			unique case (idx)
				vstc_pkg::REG_CAMERA_ID:   cfg_q.camera_id     <= pwdata[7:0];
				vstc_pkg::REG_WINDOW_LOW:  cfg_q.window_low_x  <= pwdata[9:0];
				vstc_pkg::REG_WINDOW_HIGH: cfg_q.window_high_x <= pwdata[9:0];
				vstc_pkg::REG_SPEED_SCALE: cfg_q.speed_scale   <= pwdata[9:0];
				vstc_pkg::REG_MIN_DIST:    cfg_q.min_distance  <= pwdata[11:0];
				vstc_pkg::REG_TIMEOUT:     cfg_q.timeout_ticks <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			vstc_pkg::REG_CAMERA_ID:   prdata = {24'd0, cfg_q.camera_id};
			vstc_pkg::REG_WINDOW_LOW:  prdata = {22'd0, cfg_q.window_low_x};
			vstc_pkg::REG_WINDOW_HIGH: prdata = {22'd0, cfg_q.window_high_x};
			vstc_pkg::REG_SPEED_SCALE: prdata = {22'd0, cfg_q.speed_scale};
			vstc_pkg::REG_MIN_DIST:    prdata = {20'd0, cfg_q.min_distance};
			vstc_pkg::REG_TIMEOUT:     prdata = {16'd0, cfg_q.timeout_ticks};
			default:                   prdata = 32'd0;
		endcase
	end

endmodule

>>> hw/rtl/vstc_div.sv
module vstc_div (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [vstc_pkg::DIVIDEND_W-1:0]  dividend,
	input  logic [vstc_pkg::DIVISOR_W-1:0]   divisor,
	output logic                             done,
	output logic [vstc_pkg::DIVIDEND_W-1:0]  quotient
);

	logic                             busy_q;
	logic                             done_q;
	logic [vstc_pkg::CNT_W-1:0]       cnt_q;
	logic [vstc_pkg::DIVIDEND_W-1:0]  num_q;
	logic [vstc_pkg::DIVIDEND_W-1:0]  quo_q;
	logic [vstc_pkg::DIVISOR_W-1:0]   rem_q;
	logic [vstc_pkg::DIVISOR_W-1:0]   dvs_q;
	logic [vstc_pkg::DIVISOR_W:0]     trial;
	logic [vstc_pkg::DIVISOR_W:0]     diff;
	logic                             fits;

	// one quotient bit per cycle, restoring
	assign trial = {rem_q, num_q[vstc_pkg::DIVIDEND_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	assign done     = done_q;
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= vstc_pkg::CNT_W'(vstc_pkg::DIVIDEND_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[vstc_pkg::DIVIDEND_W-2:0], 1'b0};
			quo_q <= {quo_q[vstc_pkg::DIVIDEND_W-2:0], fits};
			rem_q <= fits ? diff[vstc_pkg::DIVISOR_W-1:0] : trial[vstc_pkg::DIVISOR_W-1:0];
		end
	end

endmodule

>>> hw/rtl/visual_steering_thrust_controller_core.sv
// Visual steering thrust controller. Requests (start, distance report,
// image coordinate, tick, deactivate) enter on the request channel and
// each produces at most one thrust command on the result channel. Start,
// distance reports, ticks and filtered-out coordinates are taken on accept
// and give no result; deactivate, a stop on timeout and a turn whose window
// divisor is zero are accepted and then load the output register.
// A turn with a nonzero divisor and a forward command are accepted while the
// scaled offset is formed, pass through the bit-serial restoring divider that
// produces one quotient bit per cycle, have the quotient saturated into the
// pending result, and then load the output register.
// One request is worked on at a time; the
// next one is taken while a finished result still waits in the output
// register. Configuration lives in an APB register file at byte address
// 4*index and should be written only while the block is idle.
module visual_steering_thrust_controller_core (
	input  logic                          clk,
	input  logic                          arst_n,
	vstc_req_if.sink                      request,
	vstc_res_if.source                    result,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [vstc_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_DIV  = 3'b010,
		S_EMIT = 3'b100
	} state_t;

	vstc_pkg::cfg_t cfg;

	state_t                            state_q;
	logic [11:0]                       target_distance_q;
	logic                              distance_fresh_q;
	logic [15:0]                       stale_timer_q;
	vstc_pkg::action_t                 res_action_q;
	logic [vstc_pkg::MAG_W-1:0]        res_mag_q;
	logic                              out_valid_q;
	logic [1:0]                        out_action_q;
	logic signed [15:0]                out_port_q;
	logic signed [15:0]                out_stbd_q;

	logic                              accept;
	logic                              img_ok;
	logic                              go_left;
	logic                              go_right;
	logic                              dist_ok;
	logic [9:0]                        left_diff;
	logic [13:0]                       right_diff;
	logic [9:0]                        left_div;
	logic [9:0]                        right_div;
	logic [13:0]                       mul_a;
	logic [23:0]                       prod;
	logic [vstc_pkg::DIVIDEND_W-1:0]   dividend;
	logic [vstc_pkg::DIVISOR_W-1:0]    divisor;
	logic                              div_start;
	logic                              div_done;
	logic [vstc_pkg::DIVIDEND_W-1:0]   quotient;
	logic [vstc_pkg::MAG_W-1:0]        sat_mag;
	logic signed [15:0]                mag16;
	logic                              slot_free;

	vstc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Take a request whenever no earlier one is still being worked on.
	assign request.ready = (state_q == S_IDLE);
	assign accept        = request.valid && request.ready;

	// Image filter and window tests; the left test wins when the window
	// edges are inverted.
	assign img_ok   = request.from_partner && (request.camera == cfg.camera_id);
	assign go_left  = request.coord_value < {4'd0, cfg.window_low_x};
	assign go_right = request.coord_value > {4'd0, cfg.window_high_x};
	assign dist_ok  = request.from_partner && request.tracking &&
		(request.coord_value >= {2'd0, cfg.min_distance}) &&
		(request.coord_value <= vstc_pkg::MAX_DIST);

	// On the left the coordinate is below a 10-bit edge, so its low bits suffice.
	assign left_diff  = cfg.window_low_x - request.coord_value[9:0];
	assign right_diff = request.coord_value - {4'd0, cfg.window_high_x};
	assign left_div   = (cfg.window_low_x > vstc_pkg::LEFT_REF) ?
		cfg.window_low_x - vstc_pkg::LEFT_REF : vstc_pkg::LEFT_REF - cfg.window_low_x;
	assign right_div  = (cfg.window_high_x > vstc_pkg::RIGHT_REF) ?
		cfg.window_high_x - vstc_pkg::RIGHT_REF : vstc_pkg::RIGHT_REF - cfg.window_high_x;

	// Share one narrow multiplier between turn offset and forward distance.
	always_comb begin
		if (go_left)
			mul_a = {4'd0, left_diff};
		else if (go_right)
			mul_a = right_diff;
		else
			mul_a = {2'd0, target_distance_q};
	end

	assign prod = mul_a * {4'd0, cfg.speed_scale};

	// Turns carry the extra factor of 64 into Q1.14; forward divides by 24.
	always_comb begin
		if (go_left) begin
			dividend = {prod, 6'd0};
			divisor  = left_div;
		end else if (go_right) begin
			dividend = {prod, 6'd0};
			divisor  = right_div;
		end else begin
			dividend = {6'd0, prod};
			divisor  = vstc_pkg::FWD_DIV;
		end
	end

	assign div_start = accept && (request.cmd == vstc_pkg::CMD_IMAGE) && img_ok &&
		((go_left && left_div != '0) || (!go_left && go_right && right_div != '0) ||
		(!go_left && !go_right && distance_fresh_q));

	vstc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  (divisor),
		.done     (div_done),
		.quotient (quotient)
	);

	// Saturate the magnitude to one.
	assign sat_mag = (quotient > vstc_pkg::DIVIDEND_W'(vstc_pkg::ONE_Q14)) ?
		vstc_pkg::ONE_Q14 : quotient[vstc_pkg::MAG_W-1:0];

	// Sequencer: idle, divide when needed, then hand the result to the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q           <= S_IDLE;
			target_distance_q <= '0;
			distance_fresh_q  <= 1'b0;
			stale_timer_q     <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (request.cmd)
							vstc_pkg::CMD_START: begin
								distance_fresh_q <= 1'b0;
								stale_timer_q    <= '0;
							end
							vstc_pkg::CMD_DISTANCE: begin
								if (dist_ok) begin
									target_distance_q <= request.coord_value[11:0];
									distance_fresh_q  <= 1'b1;
								end
							end
							vstc_pkg::CMD_IMAGE: begin
								if (img_ok) begin
									if (go_left || go_right) begin
										state_q <= div_start ? S_DIV : S_EMIT;
									end else if (distance_fresh_q) begin
										distance_fresh_q <= 1'b0;
										stale_timer_q    <= '0;
										state_q          <= S_DIV;
									end else if (stale_timer_q >= cfg.timeout_ticks) begin
										state_q <= S_EMIT;
									end
								end
							end
							vstc_pkg::CMD_TICK: begin
								if (stale_timer_q != 16'hFFFF)
									stale_timer_q <= stale_timer_q + 1'b1;
							end
							vstc_pkg::CMD_DEACTIVATE: state_q <= S_EMIT;
							default: ;
						endcase
					end
				end
				S_DIV: begin
					if (div_done)
						state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (slot_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Pending result: action at accept, magnitude at accept or from the divider.
	always_ff @(posedge clk) begin
		if (accept) begin
			res_mag_q <= vstc_pkg::ONE_Q14;
			if (request.cmd == vstc_pkg::CMD_IMAGE) begin
				if (go_left)
					res_action_q <= vstc_pkg::ACT_LEFT;
				else if (go_right)
					res_action_q <= vstc_pkg::ACT_RIGHT;
				else if (distance_fresh_q)
					res_action_q <= vstc_pkg::ACT_FORWARD;
				else
					res_action_q <= vstc_pkg::ACT_STOP;
			end else begin
				res_action_q <= vstc_pkg::ACT_STOP;
			end
		end else if (state_q == S_DIV && div_done) begin
			res_mag_q <= sat_mag;
		end
	end

	// Output register: load when empty or being drained this cycle.
	assign slot_free = !out_valid_q || result.ready;
	assign mag16     = $signed({1'b0, res_mag_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_EMIT && slot_free) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_EMIT && slot_free) begin
			out_action_q <= res_action_q;
			case (res_action_q)
				vstc_pkg::ACT_LEFT: begin
					out_port_q <= -mag16;
					out_stbd_q <= mag16;
				end
				vstc_pkg::ACT_RIGHT: begin
					out_port_q <= mag16;
					out_stbd_q <= -mag16;
				end
				vstc_pkg::ACT_FORWARD: begin
					out_port_q <= mag16;
					out_stbd_q <= mag16;
				end
				default: begin
					out_port_q <= '0;
					out_stbd_q <= '0;
				end
			endcase
		end
	end

	assign result.valid            = out_valid_q;
	assign result.action           = out_action_q;
	assign result.thrust_port      = out_port_q;
	assign result.thrust_starboard = out_stbd_q;

endmodule

>>> hw/rtl/vstc_checker.sv
module vstc_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               res_valid,
	input logic               res_ready,
	input logic [1:0]         res_action,
	input logic signed [15:0] res_port,
	input logic signed [15:0] res_stbd
);

	// hold a stalled result
	property p_res_hold;
		@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_action) &&
			$stable(res_port) && $stable(res_stbd);
	endproperty
	a_res_hold: assert property (p_res_hold) else $error("result changed while stalled");

	property p_stop_zero;
		@(posedge clk) disable iff (!arst_n)
		res_valid && res_action == vstc_pkg::ACT_STOP |-> res_port == '0 && res_stbd == '0;
	endproperty
	a_stop_zero: assert property (p_stop_zero) else $error("stop with nonzero thrust");

	property p_forward;
		@(posedge clk) disable iff (!arst_n)
		res_valid && res_action == vstc_pkg::ACT_FORWARD |->
			res_port == res_stbd && res_port >= 0 && res_port <= 16'sd16384;
	endproperty
	a_forward: assert property (p_forward) else $error("forward thrust out of range");

	property p_turn;
		@(posedge clk) disable iff (!arst_n)
		res_valid && (res_action == vstc_pkg::ACT_LEFT || res_action == vstc_pkg::ACT_RIGHT) |->
			(res_port + res_stbd) == 16'sd0 && res_port >= -16'sd16384 &&
			res_port <= 16'sd16384 &&
			((res_action == vstc_pkg::ACT_LEFT) ? (res_stbd >= 0) : (res_port >= 0));
	endproperty
	a_turn: assert property (p_turn) else $error("turn thrust not mirrored or out of range");

endmodule

bind visual_steering_thrust_controller_core vstc_checker u_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.res_valid  (result.valid),
	.res_ready  (result.ready),
	.res_action (result.action),
	.res_port   (result.thrust_port),
	.res_stbd   (result.thrust_starboard)
);

>>> tb/sv/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import vstc_pkg::*;

	// Command codes the block has no use for; they must pass without effect.
	localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
	localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;

	// Cycles to let pass once the last thrust command is in: a full divide plus margin.
	localparam int SETTLE_CYCLES = 40;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_ITEMS   = 170;
	localparam int REPORT_CAP    = 200;

	typedef struct packed {
		logic [2:0]  cmd;
		logic        partner;
		logic        tracking;
		logic [7:0]  camera;
		logic [13:0] coord;
	} steer_req_t;

	typedef struct packed {
		action_t            act;
		logic signed [15:0] port;
		logic signed [15:0] stbd;
	} thrust_cmd_t;

	// One row of the directed walk: either a register write or a request,
	// with the thrust command typed in where it is plain to see.
	typedef struct packed {
		bit          reg_write;
		logic [2:0]  reg_sel;
		logic [15:0] reg_value;
		steer_req_t  req;
		bit          typed;
		thrust_cmd_t want;
	} probe_t;

	localparam thrust_cmd_t NO_CMD     = '0;
	localparam thrust_cmd_t HALT       = '{ACT_STOP, 16'sd0, 16'sd0};
	localparam thrust_cmd_t HARD_LEFT  = '{ACT_LEFT, -16'sd16384, 16'sd16384};
	localparam thrust_cmd_t HARD_RIGHT = '{ACT_RIGHT, 16'sd16384, -16'sd16384};
	localparam thrust_cmd_t FULL_AHEAD = '{ACT_FORWARD, 16'sd16384, 16'sd16384};
	localparam steer_req_t  NO_REQ     = '0;

	localparam int PROBES = 31;

	// Reset settings: camera 1, window 130..190, scale 1.5, min distance 1.5 m,
	// timeout 2000 ticks. Later rows retune the window, timeout and camera.
	localparam probe_t PROBE_TABLE [PROBES] = '{
		// deactivate straight out of reset
		'{1'b0, REG_CAMERA_ID, 16'd0, '{CMD_DEACTIVATE, 1'b0, 1'b0, 8'd0, 14'd0},
			1'b1, HALT},
		// inside the window, no distance yet, timer far from timeout
		'{1'b0, REG_CAMERA_ID, 16'd0, '{CMD_IMAGE, 1'b1, 1'b0, 8'd1, 14'd160},
			1'b0, NO_CMD},
		// wrong source, then wrong camera
		'{1'b0, REG_CAMERA_ID, 16'd0, '{CMD_IMAGE, 1'b0, 1'b1, 8'd1, 14'd0},
			1'b0, NO_CMD},
		'{1'b0, REG_CAMERA_ID, 16'd0, '{CMD_IMAGE, 1'b1, 1'b0, 8'hFE, 14'd0},
			1'b0, NO_CMD},
		// far left saturates, one pixel left is the smallest turn
		'{1'b0, REG_CAMERA_ID, 16'd0, '{CMD_IMAGE, 1'b1, 1'b0, 8'd1, 14'd0},
			1'b1, HARD_LEFT},
		'{1'b0, REG_CAMERA_ID, 16'd0, '{CMD_IMAGE, 1'b1, 1'b0, 8'd1, 14'd129},
			1'b0, NO_CMD},
		// far right saturates, one pixel right is the smallest turn
		'{1'b0, REG_CAMERA_ID, 16'd0, '{CMD_IMAGE, 1'b1, 1'b1, 8'd1, 14'h3FFF},
			1'b1, HARD_RIGHT},
		'{1'b0, REG_CAMERA_ID, 16'd0, '{CMD_IMAGE, 1'b1, 1'b0, 8'd1, 14'd191},
			1'b0, NO_CMD},
		'{1'b0, REG_CAMERA_ID, 16'd0, '{CMD_IMAGE, 1'b1, 1'b0, 8'd1, 14'd130},
			1'b0, NO_CMD},
		// distance rejects: too close, too far, wrong source, not tracked
		'{1'b0, REG_CAMERA_ID, 16'd0, '{CMD_DISTANCE, 1'b1, 1'b1, 8'd0, 14'd383},
			1'b0, NO_CMD},
		'{1'b0, REG_CAMERA_ID, 16'd0, '{CMD_DISTANCE, 1'b1, 1'b1, 8'd0, 14'd3073},
			1'b0, NO_CMD},
		'{1'b0, REG_CAMERA_ID, 16'd0, '{CMD_DISTANCE, 1'b0, 1'b1, 8'd0, 14'd1000},
			1'b0, NO_CMD},
		'{1'b0, REG_CAMERA_ID, 16'd0, '{CMD_DISTANCE, 1'b1, 1'b0, 8'd0, 14'd1000},
			1'b0, NO_CMD},
		// 12 m is accepted and drives full ahead at the right window edge
		'{1'b0, REG_CAMERA_ID, 16'd0, '{CMD_DISTANCE, 1'b1, 1'b1, 8'd0, 14'd3072},
			1'b0, NO_CMD},
		'{1'b0, REG_CAMERA_ID, 16'd0, '{CMD_IMAGE, 1'b1, 1'b0, 8'd1, 14'd190},
			1'b1, FULL_AHEAD},
		// minimum distance accepted, then used once only
		'{1'b0, REG_CAMERA_ID, 16'd0, '{CMD_DISTANCE, 1'b1, 1'b1, 8'd0, 14'd384},
			1'b0, NO_CMD},
		'{1'b0, REG_CAMERA_ID, 16'd0, '{CMD_IMAGE, 1'b1, 1'b0, 8'd1, 14'd160},
			1'b0, NO_CMD},
		'{1'b1, REG_TIMEOUT, 16'd1, NO_REQ, 1'b0, NO_CMD},
		'{1'b1, REG_WINDOW_LOW, 16'd60, NO_REQ, 1'b0, NO_CMD},
		// left edge on the left reference: zero divisor
		'{1'b0, REG_CAMERA_ID, 16'd0, '{CMD_IMAGE, 1'b1, 1'b0, 8'd1, 14'd59},
			1'b1, HARD_LEFT},
		'{1'b0, REG_CAMERA_ID, 16'd0, '{CMD_IMAGE, 1'b1, 1'b0, 8'd1, 14'd160},
			1'b0, NO_CMD},
		// one tick reaches a one-tick timeout
		'{1'b0, REG_CAMERA_ID, 16'd0, '{CMD_TICK, 1'b0, 1'b1, 8'hFF, 14'h3FFF},
			1'b0, NO_CMD},
		'{1'b0, REG_CAMERA_ID, 16'd0, '{CMD_IMAGE, 1'b1, 1'b0, 8'd1, 14'd100},
			1'b1, HALT},
		// start clears the timer again
		'{1'b0, REG_CAMERA_ID, 16'd0, '{CMD_START, 1'b1, 1'b1, 8'hFF, 14'h3FFF},
			1'b0, NO_CMD},
		'{1'b0, REG_CAMERA_ID, 16'd0, '{CMD_IMAGE, 1'b1, 1'b0, 8'd1, 14'd100},
			1'b0, NO_CMD},
		'{1'b1, REG_WINDOW_HIGH, 16'd260, NO_REQ, 1'b0, NO_CMD},
		// right edge on the right reference: zero divisor
		'{1'b0, REG_CAMERA_ID, 16'd0, '{CMD_IMAGE, 1'b1, 1'b0, 8'd1, 14'd261},
			1'b1, HARD_RIGHT},
		'{1'b0, REG_CAMERA_ID, 16'd0, '{CMD_SPARE_FIRST, 1'b1, 1'b1, 8'd1, 14'd100},
			1'b0, NO_CMD},
		'{1'b0, REG_CAMERA_ID, 16'd0, '{CMD_SPARE_LAST, 1'b1, 1'b1, 8'hFF, 14'h3FFF},
			1'b0, NO_CMD},
		'{1'b1, REG_CAMERA_ID, 16'd255, NO_REQ, 1'b0, NO_CMD},
		'{1'b0, REG_CAMERA_ID, 16'd0, '{CMD_IMAGE, 1'b1, 1'b0, 8'hFF, 14'd0},
			1'b1, HARD_LEFT}
	};

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [PADDR_W-1:0]   paddr;
	logic [31:0]          pwdata;
	logic [31:0]          prdata;
	logic                 pready;

	vstc_req_if req_ch ();
	vstc_res_if res_ch ();

	visual_steering_thrust_controller_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.request(req_ch),
		.result(res_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// Shadow of the register file and of the steering state.
	cfg_t        regs;
	logic [11:0] held_dist   = '0;
	bit          dist_new    = 1'b0;
	logic [15:0] stale_ticks = '0;

	// Thrust commands still owed by the block, oldest first.
	thrust_cmd_t thrust_expected [$];
	thrust_cmd_t head_cmd;
	int unsigned faults = 0;

	// Request sender pacing.
	int unsigned burst_left = 0;
	bit          sender_up  = 1'b0;

	// Result receiver stall pattern.
	logic [15:0] stall_mask = 16'hFFFF;
	int unsigned stall_hold = 0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Clamp a Q1.14 magnitude to one.
	function automatic logic [14:0] clip_unit(input longint unsigned q);
		return (q > 64'(ONE_Q14)) ? ONE_Q14 : q[14:0];
	endfunction

	// Turn strength: offset * scale * 64 / divisor, zero divisor saturates.
	function automatic logic [14:0] turn_strength(input logic [13:0] offset,
			input logic [9:0] divisor);
		if (divisor == '0)
			return ONE_Q14;
		return clip_unit(64'(offset) * 64'(regs.speed_scale) * 64 / 64'(divisor));
	endfunction

	function automatic thrust_cmd_t thrust_pair(input action_t act, input logic [14:0] mag,
			input bit port_back, input bit stbd_back);
		logic signed [15:0] fwd;
		fwd = signed'({1'b0, mag});
		return '{act, port_back ? -fwd : fwd, stbd_back ? -fwd : fwd};
	endfunction

	// Advance the shadow state by one request. Returns 0 when the block
	// simply drops the request; emits tells whether a thrust command follows.
	function automatic bit steer_predict(input steer_req_t r, output bit emits,
			output thrust_cmd_t cmd_out);
		logic [9:0]  span;
		logic [14:0] mag;
		emits = 1'b0;
		cmd_out = NO_CMD;
		case (r.cmd)
			CMD_START: begin
				dist_new = 1'b0;
				stale_ticks = '0;
			end
			CMD_DISTANCE: begin
				if (r.partner && r.tracking && r.coord >= 14'(regs.min_distance) &&
						r.coord <= MAX_DIST) begin
					held_dist = r.coord[11:0];
					dist_new = 1'b1;
				end
			end
			CMD_IMAGE: begin
				if (!r.partner || r.camera != regs.camera_id)
					return 1'b0;
				if (r.coord < 14'(regs.window_low_x)) begin
					span = (regs.window_low_x > LEFT_REF) ? regs.window_low_x - LEFT_REF
						: LEFT_REF - regs.window_low_x;
					mag = turn_strength(14'(regs.window_low_x) - r.coord, span);
					cmd_out = thrust_pair(ACT_LEFT, mag, 1'b1, 1'b0);
					emits = 1'b1;
				end else if (r.coord > 14'(regs.window_high_x)) begin
					span = (regs.window_high_x > RIGHT_REF) ? regs.window_high_x - RIGHT_REF
						: RIGHT_REF - regs.window_high_x;
					mag = turn_strength(r.coord - 14'(regs.window_high_x), span);
					cmd_out = thrust_pair(ACT_RIGHT, mag, 1'b0, 1'b1);
					emits = 1'b1;
				end else if (dist_new) begin
					mag = clip_unit(64'(held_dist) * 64'(regs.speed_scale) / 64'(FWD_DIV));
					dist_new = 1'b0;
					stale_ticks = '0;
					cmd_out = thrust_pair(ACT_FORWARD, mag, 1'b0, 1'b0);
					emits = 1'b1;
				end else if (stale_ticks >= regs.timeout_ticks) begin
					cmd_out = thrust_pair(ACT_STOP, '0, 1'b0, 1'b0);
					emits = 1'b1;
				end
			end
			CMD_TICK: begin
				if (stale_ticks != 16'hFFFF)
					stale_ticks = stale_ticks + 16'd1;
			end
			CMD_DEACTIVATE: begin
				cmd_out = thrust_pair(ACT_STOP, '0, 1'b0, 1'b0);
				emits = 1'b1;
			end
			default: return 1'b0;
		endcase
		return 1'b1;
	endfunction

	// Random steering traffic: mostly well-formed distance reports and image
	// coordinates for the configured camera, spread over left, inside and
	// right of the window, plus ticks, starts, deactivations and raw noise.
	function automatic steer_req_t random_request();
		steer_req_t  r;
		int unsigned pick;
		int          lo;
		int          hi;
		lo = int'(regs.window_low_x);
		hi = int'(regs.window_high_x);
		r = '{CMD_IMAGE, 1'b1, 1'($urandom), regs.camera_id, 14'd0};
		pick = $urandom_range(0, 99);
		if (pick < 20) begin
			r.cmd = CMD_DISTANCE;
			r.tracking = 1'b1;
			r.coord = 14'($urandom_range(int'(regs.min_distance), int'(MAX_DIST)));
		end else if (pick < 60) begin
			case ($urandom_range(0, 2))
				0: r.coord = (lo <= hi) ? 14'($urandom_range(lo, hi))
					: 14'($urandom_range(0, 1023));
				1: r.coord = (lo > 0) ? 14'($urandom_range(0, lo - 1)) : 14'd0;
				default: begin
					if ($urandom_range(0, 3) == 0)
						r.coord = 14'($urandom_range(hi + 1, 16383));
					else
						r.coord = 14'($urandom_range(hi + 1, hi + 150));
				end
			endcase
		end else if (pick < 78) begin
			r.cmd = CMD_TICK;
		end else if (pick < 83) begin
			r.cmd = CMD_START;
		end else if (pick < 88) begin
			r.cmd = CMD_DEACTIVATE;
		end else begin
			r = steer_req_t'(27'($urandom));
		end
		return r;
	endfunction

	function automatic cfg_t random_settings();
		cfg_t c;
		int   lo;
		int   hi;
		lo = ($urandom_range(0, 5) == 0) ? int'(LEFT_REF) : int'($urandom_range(0, 400));
		case ($urandom_range(0, 7))
			0: hi = int'(RIGHT_REF);
			1: hi = int'($urandom_range(0, 1023));
			default: hi = lo + int'($urandom_range(0, 200));
		endcase
		c.camera_id = 8'($urandom_range(0, 255));
		c.window_low_x = 10'(lo);
		c.window_high_x = 10'(hi);
		c.speed_scale = 10'($urandom_range(128, 512));
		c.min_distance = 12'($urandom_range(128, 3072));
		c.timeout_ticks = 16'($urandom_range(1, 48));
		return c;
	endfunction

	// Present one request, hold it until the block takes it, then book the
	// thrust command it owes. The sender runs in bursts with idle gaps between.
	task automatic issue_request(input steer_req_t r, input bit typed,
			input thrust_cmd_t given, output bit counted);
		bit          emits;
		thrust_cmd_t forecast;
		if (!sender_up) begin
			if ($urandom_range(0, 3) == 0)
				repeat ($urandom_range(1, 40)) @(posedge clk);
			else
				repeat ($urandom_range(1, 3)) @(posedge clk);
			if ($urandom_range(0, 7) == 0)
				burst_left = 64;
			else
				burst_left = $urandom_range(1, 16);
		end
		req_ch.valid <= 1'b1;
		req_ch.cmd <= r.cmd;
		req_ch.from_partner <= r.partner;
		req_ch.tracking <= r.tracking;
		req_ch.camera <= r.camera;
		req_ch.coord_value <= r.coord;
		sender_up = 1'b1;
		do
			@(posedge clk);
		while (!req_ch.ready);
		counted = steer_predict(r, emits, forecast);
		if (typed)
			thrust_expected.push_back(given);
		else if (emits)
			thrust_expected.push_back(forecast);
		burst_left--;
		// End of burst: drop valid until the next request goes out.
		if (burst_left == 0) begin
			req_ch.valid <= 1'b0;
			sender_up = 1'b0;
		end
	endtask

	// Drop valid, wait for every owed command, then let the divider run dry.
	task automatic settle_block();
		if (sender_up) begin
			req_ch.valid <= 1'b0;
			sender_up = 1'b0;
		end
		while (thrust_expected.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// APB write: setup cycle, then access cycle until pready.
	task automatic write_reg(input logic [2:0] sel, input logic [15:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {sel, 2'b00};
		pwdata <= 32'(value);
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (sel)
			REG_CAMERA_ID:   regs.camera_id = value[7:0];
			REG_WINDOW_LOW:  regs.window_low_x = value[9:0];
			REG_WINDOW_HIGH: regs.window_high_x = value[9:0];
			REG_SPEED_SCALE: regs.speed_scale = value[9:0];
			REG_MIN_DIST:    regs.min_distance = value[11:0];
			REG_TIMEOUT:     regs.timeout_ticks = value;
			default: ;
		endcase
	endtask

	task automatic apply_settings(input cfg_t c);
		write_reg(REG_CAMERA_ID, 16'(c.camera_id));
		write_reg(REG_WINDOW_LOW, 16'(c.window_low_x));
		write_reg(REG_WINDOW_HIGH, 16'(c.window_high_x));
		write_reg(REG_SPEED_SCALE, 16'(c.speed_scale));
		write_reg(REG_MIN_DIST, 16'(c.min_distance));
		write_reg(REG_TIMEOUT, c.timeout_ticks);
	endtask

	// Receiver: rotate a stall mask, pick a new one every so often; an
	// all-ones mask gives stretches with no backpressure at all.
	always @(posedge clk) begin
		if (stall_hold == 0) begin
			stall_mask = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom) | 16'h8001;
			stall_hold = $urandom_range(16, 160);
		end else begin
			stall_hold--;
		end
		stall_mask = {stall_mask[14:0], stall_mask[15]};
		res_ch.ready <= stall_mask[15];
	end

	// Compare every accepted thrust command with the oldest one owed.
	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (thrust_expected.size() == 0) begin
				faults++;
				if (faults <= REPORT_CAP)
					$display("%0t: thrust command with none owed: action %0d port %0d stbd %0d",
						$time, res_ch.action, res_ch.thrust_port, res_ch.thrust_starboard);
			end else begin
				head_cmd = thrust_expected.pop_front();
				if (res_ch.action !== head_cmd.act) begin
					faults++;
					if (faults <= REPORT_CAP)
						$display("%0t: action expected %0d, got %0d",
							$time, head_cmd.act, res_ch.action);
				end
				if (res_ch.thrust_port !== head_cmd.port) begin
					faults++;
					if (faults <= REPORT_CAP)
						$display("%0t: port thrust expected %0d, got %0d",
							$time, head_cmd.port, res_ch.thrust_port);
				end
				if (res_ch.thrust_starboard !== head_cmd.stbd) begin
					faults++;
					if (faults <= REPORT_CAP)
						$display("%0t: starboard thrust expected %0d, got %0d",
							$time, head_cmd.stbd, res_ch.thrust_starboard);
				end
			end
		end
	end

	initial begin
		bit          counted;
		int unsigned tally;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req_ch.valid = 1'b0;
		req_ch.cmd = CMD_START;
		req_ch.from_partner = 1'b0;
		req_ch.tracking = 1'b0;
		req_ch.camera = '0;
		req_ch.coord_value = '0;
		res_ch.ready = 1'b0;
		regs = '{8'd1, 10'd130, 10'd190, 10'd384, 12'd384, 16'd2000};

		// Hold reset, then release it for good.
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Directed walk: register rows wait for the block to go idle first.
		foreach (PROBE_TABLE[i]) begin
			if (PROBE_TABLE[i].reg_write) begin
				settle_block();
				write_reg(PROBE_TABLE[i].reg_sel, PROBE_TABLE[i].reg_value);
			end else begin
				issue_request(PROBE_TABLE[i].req, PROBE_TABLE[i].typed,
					PROBE_TABLE[i].want, counted);
			end
		end

		// Random phases: all registers at their low ends, then at their high
		// ends, then random settings with short timeouts so stops do occur.
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			settle_block();
			case (p)
				0: apply_settings('{8'd0, 10'd0, 10'd0, 10'd128, 12'd128, 16'd1});
				1: apply_settings('{8'd255, 10'd1023, 10'd1023, 10'd512, 12'd3072, 16'hFFFF});
				default: apply_settings(random_settings());
			endcase
			tally = 0;
			while (tally < PHASE_ITEMS) begin
				issue_request(random_request(), 1'b0, NO_CMD, counted);
				if (counted)
					tally++;
			end
		end

		settle_block();

		if (faults == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#30ms;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
